### rtl/hbf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbf_pkg
// Shared types and constants of the history buffer: request and result
// formats, register indexes, insert mode codes and the modulo unit interface.
// ---------------------------------------------------------------------------
package hbf_pkg;

  // fixed field widths
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 7;
  localparam int POS_W      = 6;
  localparam int CUR_W      = 6;
  localparam int NUM_W      = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INSERT_MODE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONLY_CHANGES = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_INDEX = 4'd3;

  // insert modes
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_HEAD   = 2'd1;
  localparam logic [1:0] MODE_RING   = 2'd2;
  localparam logic [1:0] MODE_INDEX  = 2'd3;

  // one input request
  typedef struct packed {
    logic [DATA_W-1:0] new_value;
    logic [DATA_W-1:0] time_stamp;
    logic              insert_enable;
    logic              clear_level;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [DATA_W-1:0] entry_value;
    logic [DATA_W-1:0] entry_time;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  list_count;
    logic              list_empty;
    logic              last_of_run;
  } out_item_t;

  // modulo unit command and answer
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

### rtl/hbf_modulo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbf_modulo
// Restoring remainder unit: num mod den, one numerator bit per cycle.
// The answer is valid in the cycle that done is high; den must be nonzero.
// ---------------------------------------------------------------------------
module hbf_modulo (
  input  logic              clk,
  input  logic              rst_n,
  input  hbf_pkg::mod_req_t req,
  output hbf_pkg::mod_rsp_t rsp
);

  localparam int STEP_W = $clog2(hbf_pkg::NUM_W + 1);

  logic [STEP_W-1:0]          step_r;
  logic [STEP_W-1:0]          step_nxt;
  logic                       done_r;
  logic                       done_nxt;
  logic [hbf_pkg::NUM_W-1:0]  num_r;
  logic [hbf_pkg::NUM_W-1:0]  num_nxt;
  logic [hbf_pkg::CNT_W-1:0]  den_r;
  logic [hbf_pkg::CNT_W-1:0]  rem_r;
  logic [hbf_pkg::CNT_W-1:0]  rem_nxt;
  logic [hbf_pkg::CNT_W:0]    shifted;
  logic [hbf_pkg::CNT_W:0]    den_ext;

  // one shift and conditional subtract
  assign shifted = {rem_r, num_r[hbf_pkg::NUM_W-1]};
  assign den_ext = {1'b0, den_r};

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      step_nxt = STEP_W'(hbf_pkg::NUM_W);
      num_nxt  = req.num;
      rem_nxt  = '0;
    end else if (step_r != '0) begin
      step_nxt = step_r - 1'b1;
      num_nxt  = {num_r[hbf_pkg::NUM_W-2:0], 1'b0};
      if (shifted >= den_ext) begin
        rem_nxt = hbf_pkg::CNT_W'(shifted - den_ext);
      end else begin
        rem_nxt = shifted[hbf_pkg::CNT_W-1:0];
      end
      done_nxt = (step_r == STEP_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### rtl/history_buffer_four_mode_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// history_buffer_four_mode_unit
// Bounded history list of values with timestamps, four insert modes,
// read out in full after every request.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one request per frame (value, timestamp, insert enable, clear
//           level); taken when in_valid is high and in_stall is low. in_stall
//           is high while a request is being worked on.
//   out_* : one result per list entry, front first, last_of_run on the final
//           one; an empty list gives one result with list_empty set.
//   cfg_* : register writes, always ready; write only while the unit is idle.
// Timing: a request passes through planning and the update, with a wait in
//   the modulo unit between them for index mode or a full ring overwrite.
//   The entries then stream from the entry memory at one result per cycle
//   while out_stall is low, through the registered memory read and the output
//   register. The length of a request grows with the list count, set by the
//   single read port of the entry memory.
// Stall: results wait in the output register; the read stream holds. The
//   next request is taken once the last read has been issued.
// Reset: list empty, cursor zero, previous value zero, registers to their
//   defaults (max_count 64, append, only on changes, index 0).
// ---------------------------------------------------------------------------
module history_buffer_four_mode_unit #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hbf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hbf_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int STORE_W = (VALUE_BITS > hbf_pkg::DATA_W) ? hbf_pkg::DATA_W : VALUE_BITS;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = hbf_pkg::CNT_W;

  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLAN  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  // logical position to memory address, wrapping once at DEPTH
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(ofs);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // count after dropping entries above the limit, keeping at least one
  function automatic logic [CW-1:0] trim(input logic [CW-1:0] cnt,
                                         input logic [CW-1:0] lim);
    logic [CW-1:0] res;
    res = cnt;
    if (cnt > lim && cnt > CW'(1)) begin
      res = (lim == '0) ? CW'(1) : lim;
    end
    return res;
  endfunction

  // configuration registers
  logic [CW-1:0]                   max_count_r;
  logic [1:0]                      mode_r;
  logic                            only_r;
  logic [hbf_pkg::NUM_W-1:0]       target_r;

  // list state
  logic [2:0]                      state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [AW-1:0]                   head_r, head_nxt;
  logic [hbf_pkg::CUR_W-1:0]       cursor_r, cursor_nxt;
  logic [STORE_W-1:0]              prev_r;
  logic                            clr_latch_r;

  // captured request
  logic [STORE_W-1:0]              val_r;
  logic [hbf_pkg::DATA_W-1:0]      time_r;
  logic                            en_r;
  logic                            rec_r;
  logic [CW-1:0]                   mod_q_r;

  // read stream
  logic [CW-1:0]                   rd_k_r, rd_k_nxt;
  logic                            p_valid_r, p_valid_nxt;
  logic [hbf_pkg::POS_W-1:0]       p_pos_r;
  logic                            p_last_r;
  logic                            p_empty_r;
  logic [CW-1:0]                   p_cnt_r;
  logic                            out_valid_r, out_valid_nxt;
  hbf_pkg::out_item_t              out_q_r;

  // entry memories
  logic [STORE_W-1:0]              value_mem [DEPTH];
  logic [hbf_pkg::DATA_W-1:0]      time_mem  [DEPTH];
  logic [STORE_W-1:0]              rd_val_r;
  logic [hbf_pkg::DATA_W-1:0]      rd_time_r;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;

  // misc combinational
  logic                            in_acc;
  logic [STORE_W-1:0]              in_val;
  logic                            changed;
  logic [CW-1:0]                   m_eff;
  logic [CW-1:0]                   c1;
  logic [CW-1:0]                   c2;
  logic [CW-1:0]                   idx;
  logic [AW-1:0]                   head_m1;
  logic [CW-1:0]                   rd_total;
  logic                            advance;
  logic                            issue;
  logic                            issue_last;
  logic [hbf_pkg::DATA_W-1:0]      val_ext;
  hbf_pkg::mod_req_t               mod_req;
  hbf_pkg::mod_rsp_t               mod_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign in_val    = in_data.new_value[STORE_W-1:0];
  assign changed   = (in_val != prev_r);
  assign m_eff     = (max_count_r > DEPTH_CNT) ? DEPTH_CNT : max_count_r;
  assign idx       = (m_eff == '0) ? '0 : mod_q_r;
  assign head_m1   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;

  // read stream control
  assign advance    = !out_valid_r || !out_stall;
  assign issue      = (state_r == S_READ) && advance;
  assign rd_total   = (count_r == '0) ? CW'(1) : count_r;
  assign issue_last = (rd_k_r + CW'(1) == rd_total);
  assign rd_en      = issue && (count_r != '0);
  assign rd_addr    = phys(head_r, rd_k_r);

  // modulo requests: index mode or a full ring
  always_comb begin
    mod_req.start = 1'b0;
    mod_req.num   = target_r;
    mod_req.den   = m_eff;
    if (state_r == S_PLAN && en_r) begin
      if (mode_r == hbf_pkg::MODE_INDEX && m_eff != '0) begin
        mod_req.start = 1'b1;
      end else if (mode_r == hbf_pkg::MODE_RING && rec_r && m_eff != '0 &&
                   count_r != '0 && count_r >= m_eff) begin
        mod_req.start = 1'b1;
        mod_req.num   = hbf_pkg::NUM_W'(cursor_r) + hbf_pkg::NUM_W'(1);
        mod_req.den   = count_r;
      end
    end
  end

  hbf_modulo u_modulo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // sequencer and list update
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    cursor_nxt = cursor_r;
    rd_k_nxt   = rd_k_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    c1         = count_r;
    c2         = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PLAN;
          if (in_data.clear_level && !clr_latch_r) begin
            count_nxt = '0;
          end
        end
      end
      S_PLAN: begin
        state_nxt = mod_req.start ? S_MOD : S_APPLY;
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_READ;
        rd_k_nxt  = '0;
        if (en_r) begin
          case (mode_r)
            hbf_pkg::MODE_APPEND: begin
              if (rec_r) begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_r, count_r);
                c1         = count_r + CW'(1);
                c2         = trim(c1, m_eff);
                count_nxt  = c2;
                head_nxt   = phys(head_r, c1 - c2);
                cursor_nxt = hbf_pkg::CUR_W'(c2 - CW'(1));
              end
            end
            hbf_pkg::MODE_HEAD: begin
              if (rec_r) begin
                wr_en      = 1'b1;
                wr_addr    = head_m1;
                head_nxt   = head_m1;
                count_nxt  = trim(count_r + CW'(1), m_eff);
                cursor_nxt = '0;
              end
            end
            hbf_pkg::MODE_RING: begin
              if (rec_r) begin
                if (m_eff != '0) begin
                  wr_en = 1'b1;
                  if (count_r == '0) begin
                    wr_addr = head_r;
                    c1      = CW'(1);
                  end else if (count_r < m_eff) begin
                    wr_addr    = phys(head_r, count_r);
                    c1         = count_r + CW'(1);
                    cursor_nxt = hbf_pkg::CUR_W'(count_r);
                  end else begin
                    wr_addr    = phys(head_r, mod_q_r);
                    cursor_nxt = hbf_pkg::CUR_W'(mod_q_r);
                  end
                end
                count_nxt = trim(c1, m_eff);
              end
            end
            default: begin
              c1        = trim(count_r, m_eff);
              count_nxt = c1;
              if (rec_r) begin
                wr_en = 1'b1;
                if (c1 <= idx) begin
                  wr_addr   = phys(head_r, c1);
                  count_nxt = c1 + CW'(1);
                end else begin
                  wr_addr = phys(head_r, idx);
                end
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (issue) begin
          rd_k_nxt = rd_k_r + CW'(1);
          if (issue_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // read pipeline handshake
  always_comb begin
    p_valid_nxt   = p_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = p_valid_r;
      p_valid_nxt   = issue;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      cursor_r    <= '0;
      prev_r      <= '0;
      clr_latch_r <= 1'b0;
      rd_k_r      <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      max_count_r <= CW'(64);
      mode_r      <= hbf_pkg::MODE_APPEND;
      only_r      <= 1'b1;
      target_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      cursor_r    <= cursor_nxt;
      rd_k_r      <= rd_k_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        prev_r      <= in_val;
        clr_latch_r <= in_data.clear_level;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hbf_pkg::REG_MAX_COUNT:    max_count_r <= cfg_data[CW-1:0];
          hbf_pkg::REG_INSERT_MODE:  mode_r      <= cfg_data[1:0];
          hbf_pkg::REG_ONLY_CHANGES: only_r      <= cfg_data[0];
          hbf_pkg::REG_TARGET_INDEX: target_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // request capture and modulo result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_r  <= in_val;
      time_r <= in_data.time_stamp;
      en_r   <= in_data.insert_enable;
      rec_r  <= changed || !only_r;
    end
    if (state_r == S_MOD && mod_rsp.done) begin
      mod_q_r <= mod_rsp.rem;
    end
  end

  // entry memories, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= val_r;
      time_mem[wr_addr]  <= time_r;
    end
    if (rd_en) begin
      rd_val_r  <= value_mem[rd_addr];
      rd_time_r <= time_mem[rd_addr];
    end
  end

  // read stage tags
  always_ff @(posedge clk) begin
    if (issue) begin
      p_pos_r   <= hbf_pkg::POS_W'(rd_k_r);
      p_last_r  <= issue_last;
      p_empty_r <= (count_r == '0);
      p_cnt_r   <= count_r;
    end
  end

  always_comb begin
    val_ext = '0;
    val_ext[STORE_W-1:0] = rd_val_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance && p_valid_r) begin
      out_q_r.entry_value <= p_empty_r ? '0 : val_ext;
      out_q_r.entry_time  <= p_empty_r ? '0 : rd_time_r;
      out_q_r.position    <= p_empty_r ? '0 : p_pos_r;
      out_q_r.list_count  <= p_cnt_r;
      out_q_r.list_empty  <= p_empty_r;
      out_q_r.last_of_run <= p_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  // the list never outgrows the memory
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PLAN) || (count_r <= DEPTH_CNT))
    else $error("entry count above depth");

  // an empty-list result is the only and last one of its frame
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.list_empty) |-> (out_data.last_of_run && out_data.position == '0))
    else $error("empty list result malformed");

  // the last entry sits at position count - 1
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_of_run && !out_data.list_empty) |->
      (CW'(out_data.position) + CW'(1) == out_data.list_count))
    else $error("last result position mismatch");

  // the modulo unit answers only while the sequencer waits for it
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_MOD))
    else $error("modulo answer outside wait state");

  // no write to the entry memory while entries are streaming out
  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("entry write during readout");

endmodule
